>>> src/tkf_pkg.sv
// Package for the three-axis Kalman filter: sizes, types, codes and command bundle.
`timescale 1ns / 1ps
`default_nettype none
package tkf_pkg;

  // Number of independent filter channels
  localparam int AXES = 3;

  // Gain divider: quotient never exceeds 1.0 in Q1.16, so 17 quotient bits
  localparam int DIV_STEPS = 17;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int GAIN_W    = DIV_STEPS;
  localparam logic [GAIN_W-1:0] ONE_Q16 = GAIN_W'(65536);

  // Configuration register indexes and reset values
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE = CFG_IDX_W'(1);
  localparam logic [15:0] MEAS_NOISE_RST = 16'd256;
  localparam logic [15:0] PROC_NOISE_RST = 16'd26;

  // Signed Q16.16 sample / estimate and unsigned Q16.16 variance
  typedef logic signed [31:0] q16_t;
  typedef logic [31:0]        var_t;
  typedef logic [15:0]        noise_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRED,
    ST_DINIT,
    ST_DIV,
    ST_MUL,
    ST_COMMIT
  } tkf_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;   // latch samples, square the noise registers
    logic pred;      // predicted variance Pp = P + Q
    logic div_init;  // load divider with Pp*65536 / (Pp + R)
    logic div_step;  // one restoring division step on every axis
    logic mul;       // gain products
    logic commit;    // write new estimate and variance
  } tkf_cmd_t;

endpackage
`default_nettype wire

>>> src/three_axis_kalman_filter.sv
// Top level of the three-axis Kalman filter: ports, config registers, result register.
//
// Input channel in_valid/in_ready carries one Q16.16 sample per axis; each
// item produces exactly one result item on out_valid/out_ready holding the
// three updated Q16.16 estimates, saturated to 32 signed bits.
// Each axis is an independent scalar Kalman channel (identity model).
// The gain comes from the 17-step restoring gain divider, one quotient bit
// per cycle, with the three axes dividing side by side.
// in_ready is high only while the controller is idle.
// The result sits in an output register; the next item is accepted while
// it waits. If the receiver stalls, the controller holds its update in the
// commit state until the output register is free, so nothing is lost.
// Configuration: cfg_we with cfg_index 0 (measurement noise) or 1 (process
// noise), Q8.8; other indexes are ignored. Write only while idle.
// Reset (rst_n low, synchronous) clears estimates and variances, loads
// noise registers with 256 and 26, and empties the output register.
`timescale 1ns / 1ps
`default_nettype none
module three_axis_kalman_filter
  import tkf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic signed [31:0]   in_sample_x,
  input  wire logic signed [31:0]   in_sample_y,
  input  wire logic signed [31:0]   in_sample_z,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [31:0]        out_estimate_x,
  output logic signed [31:0]        out_estimate_y,
  output logic signed [31:0]        out_estimate_z,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_wdata
);

  noise_t   meas_noise_r, proc_noise_r;
  logic     out_valid_r;
  q16_t     out_est_r [AXES];
  q16_t     sample    [AXES];
  q16_t     est_new   [AXES];
  logic     out_free;
  tkf_cmd_t cmd;

  assign sample[0] = in_sample_x;
  assign sample[1] = in_sample_y;
  assign sample[2] = in_sample_z;

  assign out_free = !out_valid_r || out_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meas_noise_r <= MEAS_NOISE_RST;
      proc_noise_r <= PROC_NOISE_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MEAS_NOISE) meas_noise_r <= cfg_wdata;
      if (cfg_index == CFG_PROC_NOISE) proc_noise_r <= cfg_wdata;
    end
  end

  tkf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  tkf_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sample     (sample),
    .meas_noise (meas_noise_r),
    .proc_noise (proc_noise_r),
    .est_new    (est_new)
  );

  // Result register valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int a = 0; a < AXES; a++) out_est_r[a] <= est_new[a];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_estimate_x = out_est_r[0];
  assign out_estimate_y = out_est_r[1];
  assign out_estimate_z = out_est_r[2];

  // A commit never overwrites a result still waiting for the receiver
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd.commit)
    else $error("result register overwritten");

endmodule
`default_nettype wire

>>> src/tkf_ctrl.sv
// Controller state machine for the three-axis Kalman filter.
`timescale 1ns / 1ps
`default_nettype none
module tkf_ctrl
  import tkf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic out_free,
  output logic      in_ready,
  output tkf_cmd_t  cmd
);

  tkf_state_t state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic div_last;

  assign div_last = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));

  // State and step counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_PRED;
      end
      ST_PRED: begin
        state_nxt = ST_DINIT;
      end
      ST_DINIT: begin
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + DIV_CNT_W'(1);
        if (div_last) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_PRED:   cmd.pred     = 1'b1;
      ST_DINIT:  cmd.div_init = 1'b1;
      ST_DIV:    cmd.div_step = 1'b1;
      ST_MUL:    cmd.mul      = 1'b1;
      ST_COMMIT: cmd.commit   = out_free;
      default:   cmd          = '0;
    endcase
  end

  // An accepted item always starts the prediction step
  a_accept_pred: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_PRED))
    else $error("accepted item did not enter prediction");

  // Division never runs past its last quotient bit
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r < DIV_CNT_W'(DIV_STEPS)))
    else $error("divider step count overran");

endmodule
`default_nettype wire

>>> src/tkf_datapath.sv
// Datapath: per-axis state, gain divider lanes, gain multipliers and update.
`timescale 1ns / 1ps
`default_nettype none
module tkf_datapath
  import tkf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire tkf_cmd_t cmd,
  input  wire q16_t   sample [AXES],
  input  wire noise_t meas_noise,
  input  wire noise_t proc_noise,
  output q16_t        est_new [AXES]
);

  // Filter state
  q16_t est_r [AXES];
  var_t var_r [AXES];

  // Per-item working registers
  var_t                r_r, q_r;
  q16_t                z_r    [AXES];
  var_t                pp_r   [AXES];
  logic [32:0]         den_r  [AXES];
  logic [32:0]         rem_r  [AXES];
  logic [GAIN_W-1:0]   dvd_r  [AXES];
  logic [GAIN_W-1:0]   quo_r  [AXES];
  logic [GAIN_W-1:0]   gain_r [AXES];
  logic signed [50:0]  prod_e_r [AXES];
  logic [48:0]         prod_p_r [AXES];

  logic [32:0]         pp_sum   [AXES];
  logic [34:0]         trial    [AXES];
  logic [GAIN_W-1:0]   gain_nxt [AXES];
  logic signed [32:0]  err      [AXES];
  logic signed [34:0]  corr     [AXES];
  logic signed [35:0]  est_sum  [AXES];

  // Per-lane combinational pieces
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      pp_sum[a]   = {1'b0, var_r[a]} + {1'b0, q_r};
      trial[a]    = {1'b0, rem_r[a], dvd_r[a][GAIN_W-1]} - {2'b00, den_r[a]};
      gain_nxt[a] = (den_r[a] == '0) ? '0 : quo_r[a];
      err[a]      = 33'(z_r[a]) - 33'(est_r[a]);
      corr[a]     = prod_e_r[a][50:16];
      est_sum[a]  = 36'(est_r[a]) + 36'(corr[a]);
      if (est_sum[a] > 36'sd2147483647)
        est_new[a] = 32'sh7FFFFFFF;
      else if (est_sum[a] < -36'sd2147483648)
        est_new[a] = 32'sh80000000;
      else
        est_new[a] = est_sum[a][31:0];
    end
  end

  // Working registers: capture, predict, divide, multiply
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r_r <= 32'(meas_noise) * 32'(meas_noise);
      q_r <= 32'(proc_noise) * 32'(proc_noise);
    end
    for (int a = 0; a < AXES; a++) begin
      if (cmd.capture) z_r[a] <= sample[a];
      // Predicted variance, saturated to 32 bits
      if (cmd.pred) pp_r[a] <= pp_sum[a][32] ? '1 : pp_sum[a][31:0];
      // Dividend Pp*65536: top bits preload the remainder
      if (cmd.div_init) begin
        den_r[a] <= {1'b0, pp_r[a]} + {1'b0, r_r};
        rem_r[a] <= {2'b00, pp_r[a][31:1]};
        dvd_r[a] <= {pp_r[a][0], 16'h0000};
        quo_r[a] <= '0;
      end
      // Restoring division, one quotient bit per cycle
      if (cmd.div_step) begin
        if (!trial[a][34]) rem_r[a] <= trial[a][32:0];
        else               rem_r[a] <= {rem_r[a][31:0], dvd_r[a][GAIN_W-1]};
        dvd_r[a] <= {dvd_r[a][GAIN_W-2:0], 1'b0};
        quo_r[a] <= {quo_r[a][GAIN_W-2:0], ~trial[a][34]};
      end
      // Gain products
      if (cmd.mul) begin
        gain_r[a]   <= gain_nxt[a];
        prod_e_r[a] <= 51'($signed({1'b0, gain_nxt[a]}) * err[a]);
        prod_p_r[a] <= 49'((ONE_Q16 - gain_nxt[a]) * pp_r[a]);
      end
    end
  end

  // Filter state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < AXES; a++) begin
        est_r[a] <= '0;
        var_r[a] <= '0;
      end
    end else if (cmd.commit) begin
      for (int a = 0; a < AXES; a++) begin
        est_r[a] <= est_new[a];
        var_r[a] <= prod_p_r[a][47:16];
      end
    end
  end

  // Gain is a fraction of at most one
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul |=> (gain_r[0] <= ONE_Q16))
    else $error("gain above one");

  // Partial remainder stays below a nonzero divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step && (den_r[0] != '0)) |-> (rem_r[0] < den_r[0]))
    else $error("divider remainder out of range");

  // Zero denominator forces a zero gain
  a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mul && (den_r[AXES-1] == '0)) |=> (gain_r[AXES-1] == '0))
    else $error("zero denominator gave nonzero gain");

endmodule
`default_nettype wire
